// ===== rtl/lpt_pkg.sv =====
// Shared types and constants for the LRU page translator.
package lpt_pkg;

  localparam int unsigned FRAME_COUNT_D = 128;
  localparam int unsigned PAGE_COUNT_D  = 256;
  localparam int unsigned PAGE_BYTES_D  = 256;
  localparam int unsigned STAMP_BITS_D  = 32;

  localparam int unsigned VA_W   = 16;
  localparam int unsigned PAGE_W = 8;
  localparam int unsigned OFF_W  = 8;
  localparam int unsigned FRM_W  = 7;
  localparam int unsigned PA_W   = 15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_OWNER,
    ST_UNMAP,
    ST_COMMIT,
    ST_OUT
  } lpt_state_t;

endpackage

// ===== rtl/lpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/lru_page_translator.sv =====
// Top level of the demand-paging address translator with LRU replacement.
// A hit, or a fault that finds a free frame, passes through the decision, write-back and
// output states before its result is in the output register. A fault with every frame in
// use first scans the stamp memory one frame per cycle, as the stamp memory has a single
// read port, then reads the victim's owner and unmaps that page before write-back and output.
// After reset a clearing pass marks every page unmapped before the first item is accepted.
// The next item is accepted once the result has moved into the output register, so a
// stalled output delays it.
module lru_page_translator #(
  parameter int unsigned FRAME_COUNT = lpt_pkg::FRAME_COUNT_D,
  parameter int unsigned PAGE_COUNT  = lpt_pkg::PAGE_COUNT_D,
  parameter int unsigned PAGE_BYTES  = lpt_pkg::PAGE_BYTES_D,
  parameter int unsigned STAMP_BITS  = lpt_pkg::STAMP_BITS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // virtual_address[15:0]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // page_number[7:0], page_offset[15:8], frame_number[22:16],
  // physical_address[37:23], page_fault[38], evict_valid[39],
  // evicted_page[47:40]
  output logic [47:0] out_tdata
);

  localparam int unsigned FW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned OW  = $clog2(PAGE_BYTES);
  localparam int unsigned MW  = FW + 1;
  localparam int unsigned CW  = PW + 1;
  localparam int unsigned FCW = FW + 1;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  lpt_pkg::lpt_state_t state_r, state_nxt;

  logic [CW-1:0]         clr_r;
  logic                  clr_done;
  logic [lpt_pkg::VA_W-1:0] va_r;
  logic [PW-1:0]         page;
  logic [OW-1:0]         offset;
  logic [STAMP_BITS-1:0] cnt_r;
  logic [FRAME_COUNT-1:0] free_r;
  logic [FCW-1:0]        scan_r;
  logic [FW-1:0]         best_r;
  logic [STAMP_BITS-1:0] low_r;
  logic                  scan_take;
  logic [FW-1:0]         frame_r;
  logic                  fault_r, evict_r;
  logic [PW-1:0]         evpage_r;
  logic [PW-1:0]         owner_r;
  logic                  any_free;
  logic [FW-1:0]         free_idx;

  logic          pm_we;
  logic [PW-1:0] pm_wa, pm_ra;
  logic [MW-1:0] pm_wd, pm_rd;
  logic          st_we;
  logic [FW-1:0] st_wa, st_ra;
  logic [STAMP_BITS-1:0] st_wd, st_rd;
  logic          ow_we;
  logic [FW-1:0] ow_ra;
  logic [PW-1:0] ow_rd;

  logic        out_v_r;
  logic [47:0] out_d_r;

  assign page      = PW'((va_r >> OW) % PAGE_COUNT);
  assign offset    = va_r[OW-1:0];
  assign clr_done  = clr_r[CW-1:0] == CW'(PAGE_COUNT);
  assign scan_take = (scan_r == FCW'(1)) || (st_rd < low_r);

  lpt_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT)) u_page_map (
    .clk, .wr_en(pm_we), .wr_addr(pm_wa), .wr_data(pm_wd), .rd_addr(pm_ra), .rd_data(pm_rd)
  );
  lpt_ram #(.WIDTH(STAMP_BITS), .DEPTH(FRAME_COUNT)) u_stamp (
    .clk, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd), .rd_addr(st_ra), .rd_data(st_rd)
  );
  lpt_ram #(.WIDTH(PW), .DEPTH(FRAME_COUNT)) u_owner (
    .clk, .wr_en(ow_we), .wr_addr(frame_r), .wr_data(page), .rd_addr(ow_ra), .rd_data(ow_rd)
  );

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        any_free = 1'b1;
        free_idx = FW'(i);
      end
    end
  end

  assign in_tready = (state_r == lpt_pkg::ST_IDLE) && clr_done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpt_pkg::ST_IDLE:      if (in_tvalid && in_tready) state_nxt = lpt_pkg::ST_LOOKUP;
      lpt_pkg::ST_LOOKUP: begin
        if (pm_rd[MW-1] || any_free) begin
          state_nxt = lpt_pkg::ST_COMMIT;
        end else if (FRAME_COUNT > 1) begin
          state_nxt = lpt_pkg::ST_SCAN;
        end else begin
          state_nxt = lpt_pkg::ST_SCAN_LAST;
        end
      end
      lpt_pkg::ST_SCAN:
        if (scan_r == FCW'(FRAME_COUNT - 1)) state_nxt = lpt_pkg::ST_SCAN_LAST;
      lpt_pkg::ST_SCAN_LAST: state_nxt = lpt_pkg::ST_OWNER;
      lpt_pkg::ST_OWNER:     state_nxt = lpt_pkg::ST_UNMAP;
      lpt_pkg::ST_UNMAP:     state_nxt = lpt_pkg::ST_COMMIT;
      lpt_pkg::ST_COMMIT:    state_nxt = lpt_pkg::ST_OUT;
      lpt_pkg::ST_OUT:       if (!out_v_r || out_tready) state_nxt = lpt_pkg::ST_IDLE;
      default:               state_nxt = lpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pm_we = 1'b0;
    pm_wa = page;
    pm_wd = '0;
    pm_ra = page;
    st_we = 1'b0;
    st_wa = frame_r;
    st_wd = cnt_r;
    st_ra = scan_r[FW-1:0];
    ow_we = 1'b0;
    ow_ra = best_r;
    if (!clr_done) begin
      pm_we = 1'b1;
      pm_wa = clr_r[PW-1:0];
    end else begin
      case (state_r)
        lpt_pkg::ST_IDLE:  pm_ra = PW'((in_tdata >> OW) % PAGE_COUNT);
        lpt_pkg::ST_SCAN_LAST: begin
          // The last stamp may still replace the victim, so read the owner of the final one.
          if (scan_take) ow_ra = FW'(scan_r - 1'b1);
        end
        lpt_pkg::ST_OWNER: pm_ra = ow_rd;
        lpt_pkg::ST_UNMAP: begin
          if (pm_rd[MW-1] && pm_rd[FW-1:0] == frame_r) begin
            pm_we = 1'b1;
            pm_wa = owner_r;
          end
        end
        lpt_pkg::ST_COMMIT: begin
          st_we = 1'b1;
          if (fault_r) begin
            pm_we = 1'b1;
            pm_wd = {1'b1, frame_r};
            ow_we = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpt_pkg::ST_IDLE;
      clr_r   <= '0;
      cnt_r   <= '0;
      free_r  <= '1;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (!clr_done) clr_r <= clr_r + 1'b1;
      if (state_r == lpt_pkg::ST_OUT && (!out_v_r || out_tready)) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        lpt_pkg::ST_IDLE: begin
          va_r    <= in_tdata;
          scan_r  <= '0;
          evict_r <= 1'b0;
          evpage_r <= '0;
        end
        lpt_pkg::ST_LOOKUP: begin
          fault_r <= !pm_rd[MW-1];
          if (pm_rd[MW-1]) begin
            frame_r <= pm_rd[FW-1:0];
          end else if (any_free) begin
            frame_r <= free_idx;
            free_r[free_idx] <= 1'b0;
          end
          scan_r <= scan_r + 1'b1;
        end
        lpt_pkg::ST_SCAN, lpt_pkg::ST_SCAN_LAST: begin
          if (scan_take) begin
            low_r  <= st_rd;
            best_r <= FW'(scan_r - 1'b1);
          end
          if (scan_r != FCW'(FRAME_COUNT)) scan_r <= scan_r + 1'b1;
        end
        lpt_pkg::ST_OWNER: frame_r <= best_r;
        lpt_pkg::ST_UNMAP: begin
          if (pm_rd[MW-1] && pm_rd[FW-1:0] == frame_r) begin
            evict_r  <= 1'b1;
            evpage_r <= owner_r;
          end
        end
        lpt_pkg::ST_COMMIT: if (cnt_r != STAMP_MAX) cnt_r <= cnt_r + 1'b1;
        lpt_pkg::ST_OUT: begin
          if (!out_v_r || out_tready) begin
            out_d_r <= {8'(evpage_r), evict_r, fault_r,
                        15'(({{(32-FW){1'b0}}, frame_r} * 32'(PAGE_BYTES))
                            + {{(32-OW){1'b0}}, offset}),
                        7'(frame_r), 8'(offset), 8'(page)};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lpt_pkg::ST_OWNER) owner_r <= ow_rd;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
